>>> hdl/e2q_pkg.sv
package e2q_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int QUAT_BITS  = 16;
   localparam int FRAC       = 30;
   localparam int ITERS      = 32;
   localparam int IW         = 34;
   localparam int SH         = 32 - QUAT_BITS;
   localparam int LIM        = 1 << (QUAT_BITS - 2);

   localparam logic signed [IW-1:0] HALF_PI_Q   = 34'sd1686629713;
   localparam logic signed [IW-1:0] PI_Q        = 34'sd3373259426;
   localparam logic signed [IW-1:0] CORDIC_GAIN = 34'sd652032874;

   function automatic logic signed [IW-1:0] atan_val(input logic [4:0] idx);
      logic signed [IW-1:0] r;
      case (idx)
         5'd0:  r = 34'sh3243F6A8;
         5'd1:  r = 34'sh1DAC6705;
         5'd2:  r = 34'sh0FADBAFC;
         5'd3:  r = 34'sh07F56EA6;
         5'd4:  r = 34'sh03FEAB76;
         5'd5:  r = 34'sh01FFD55B;
         5'd6:  r = 34'sh00FFFAAA;
         5'd7:  r = 34'sh007FFF55;
         5'd8:  r = 34'sh003FFFEA;
         5'd9:  r = 34'sh001FFFFD;
         5'd10: r = 34'sh000FFFFF;
         5'd11: r = 34'sh0007FFFF;
         5'd12: r = 34'sh0003FFFF;
         5'd13: r = 34'sh0001FFFF;
         5'd14: r = 34'sh0000FFFF;
         5'd15: r = 34'sh00007FFF;
         5'd16: r = 34'sh00003FFF;
         5'd17: r = 34'sh00001FFF;
         5'd18: r = 34'sh00000FFF;
         5'd19: r = 34'sh000007FF;
         5'd20: r = 34'sh000003FF;
         5'd21: r = 34'sh000001FF;
         5'd22: r = 34'sh000000FF;
         5'd23: r = 34'sh0000007F;
         5'd24: r = 34'sh0000003F;
         5'd25: r = 34'sh0000001F;
         5'd26: r = 34'sh0000000F;
         5'd27: r = 34'sh00000008;
         5'd28: r = 34'sh00000004;
         5'd29: r = 34'sh00000002;
         5'd30: r = 34'sh00000001;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/euler_to_quaternion_top.sv
// Throughput: one request per cycle; busy is always low.
// The pipeline is set by 33 CORDIC stages and 6 product and rounding stages.
// Reset clears only the valid bits travelling with the data; nothing else.
module euler_to_quaternion_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0] req_roll_angle,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0] req_pitch_angle,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0] req_yaw_angle,
   output logic                                  rsp_valid,
   output logic signed [e2q_pkg::QUAT_BITS-1:0]  rsp_quat_w,
   output logic signed [e2q_pkg::QUAT_BITS-1:0]  rsp_quat_x,
   output logic signed [e2q_pkg::QUAT_BITS-1:0]  rsp_quat_y,
   output logic signed [e2q_pkg::QUAT_BITS-1:0]  rsp_quat_z
);
   import e2q_pkg::*;

   localparam int LAT = ITERS + 1 + 6;

   logic [LAT-1:0]       vld_ff;
   logic signed [IW-1:0] cr, sr, cp, sp, cy, sy;
   logic signed [IW-1:0] p1_ff [4];
   logic signed [IW-1:0] p1b_ff [2];
   logic signed [IW-1:0] t_ff [8];
   logic signed [IW-1:0] t3_ff [8];
   logic signed [IW-1:0] px_ff [4];
   logic signed [IW+1:0] s_ff [4];
   logic signed [QUAT_BITS-1:0] q_ff [4];
   logic signed [IW-1:0] c3a_ff, c3b_ff;

   e2q_cordic u_roll  (.clock(clock), .angle(req_roll_angle),  .cos_out(cr), .sin_out(sr));
   e2q_cordic u_pitch (.clock(clock), .angle(req_pitch_angle), .cos_out(cp), .sin_out(sp));
   e2q_cordic u_yaw   (.clock(clock), .angle(req_yaw_angle),   .cos_out(cy), .sin_out(sy));

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end
   assign rsp_valid = vld_ff[LAT-1];

   // Stage A: register the six sines and cosines.
   always_ff @(posedge clock) begin
      p1_ff[0] <= cr; p1_ff[1] <= sr; p1_ff[2] <= cp; p1_ff[3] <= sp;
      p1b_ff[0] <= cy; p1b_ff[1] <= sy;
   end

   // Fixed-point product of two values, scaled back by FRAC bits.
   function automatic logic signed [IW-1:0] mulq(input logic signed [IW-1:0] a,
                                                 input logic signed [IW-1:0] b);
      logic signed [2*IW-1:0] p;
      p = a * b;
      return IW'(p >>> FRAC);
   endfunction

   // Stage B: cr*cp, sr*sp, sr*cp, cr*sp; yaw terms carried along.
   always_ff @(posedge clock) begin
      t_ff[0] <= mulq(p1_ff[0], p1_ff[2]);
      t_ff[1] <= mulq(p1_ff[1], p1_ff[3]);
      t_ff[2] <= mulq(p1_ff[1], p1_ff[2]);
      t_ff[3] <= mulq(p1_ff[0], p1_ff[3]);
      c3a_ff  <= p1b_ff[0];
      c3b_ff  <= p1b_ff[1];
   end

   // Stage C: the eight triple products.
   always_ff @(posedge clock) begin
      t3_ff[0] <= mulq(t_ff[0], c3a_ff);
      t3_ff[1] <= mulq(t_ff[1], c3b_ff);
      t3_ff[2] <= mulq(t_ff[2], c3a_ff);
      t3_ff[3] <= mulq(t_ff[3], c3b_ff);
      t3_ff[4] <= mulq(t_ff[3], c3a_ff);
      t3_ff[5] <= mulq(t_ff[2], c3b_ff);
      t3_ff[6] <= mulq(t_ff[0], c3b_ff);
      t3_ff[7] <= mulq(t_ff[1], c3a_ff);
   end

   // Stage D: sums and differences.
   always_ff @(posedge clock) begin
      s_ff[0] <= (IW+2)'(t3_ff[0]) + (IW+2)'(t3_ff[1]);
      s_ff[1] <= (IW+2)'(t3_ff[2]) - (IW+2)'(t3_ff[3]);
      s_ff[2] <= (IW+2)'(t3_ff[4]) + (IW+2)'(t3_ff[5]);
      s_ff[3] <= (IW+2)'(t3_ff[6]) - (IW+2)'(t3_ff[7]);
   end

   // Stage E: round half up, then clamp to plus or minus one.
   for (genvar k = 0; k < 4; k++) begin : g_out
      logic signed [IW+1:0] r;
      always_comb begin
         if (SH > 0) r = (s_ff[k] + (IW+2)'(1 <<< (SH - 1))) >>> SH;
         else        r = s_ff[k];
      end
      always_ff @(posedge clock) begin
         if (r > (IW+2)'(LIM))       px_ff[k] <= IW'(LIM);
         else if (r < -(IW+2)'(LIM)) px_ff[k] <= -IW'(LIM);
         else                        px_ff[k] <= IW'(r);
         q_ff[k] <= px_ff[k][QUAT_BITS-1:0];
      end
   end

   assign rsp_quat_w = q_ff[0];
   assign rsp_quat_x = q_ff[1];
   assign rsp_quat_y = q_ff[2];
   assign rsp_quat_z = q_ff[3];
endmodule

>>> hdl/e2q_cordic.sv
module e2q_cordic (
   input  logic                                 clock,
   input  logic signed [e2q_pkg::ANGLE_BITS-1:0] angle,
   output logic signed [e2q_pkg::IW-1:0]        cos_out,
   output logic signed [e2q_pkg::IW-1:0]        sin_out
);
   import e2q_pkg::*;

   // One register stage per iteration, plus one for the quadrant fold.
   logic signed [IW-1:0] x_ff [ITERS+1];
   logic signed [IW-1:0] y_ff [ITERS+1];
   logic signed [IW-1:0] z_ff [ITERS+1];
   logic                 neg_ff [ITERS+1];
   logic signed [IW-1:0] h;
   logic signed [IW-1:0] z_in;
   logic                 neg_in;

   always_comb begin
      h = IW'(angle) <<< (32 - ANGLE_BITS);
      z_in = h;
      neg_in = 1'b0;
      if (h > HALF_PI_Q) begin
         z_in = PI_Q - h;
         neg_in = 1'b1;
      end else if (h < -HALF_PI_Q) begin
         z_in = -PI_Q - h;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]   <= CORDIC_GAIN;
      y_ff[0]   <= '0;
      z_ff[0]   <= z_in;
      neg_ff[0] <= neg_in;
   end

   for (genvar i = 0; i < ITERS; i++) begin : g_it
      always_ff @(posedge clock) begin
         neg_ff[i+1] <= neg_ff[i];
         if (!z_ff[i][IW-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_val(5'(i));
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_val(5'(i));
         end
      end
   end

   assign cos_out = neg_ff[ITERS] ? -x_ff[ITERS] : x_ff[ITERS];
   assign sin_out = y_ff[ITERS];
endmodule
